@@ sv/ray_voxel_traversal_3d_defines.svh @@
// Assertion macros used by the checker file of the voxel traversal block.
`ifndef RAY_VOXEL_TRAVERSAL_3D_DEFINES_SVH
`define RAY_VOXEL_TRAVERSAL_3D_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVT_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("rvt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RVT_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("rvt assertion failed");

`endif

@@ sv/rvt_pkg.sv @@
// ----------------------------------------------------------------------------
// rvt_pkg
// Shared constants of the voxel traversal block: widths, codes, reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rvt_pkg;

	// Default parameter values.
	localparam int GRID_BITS_DEF   = 10;
	localparam int T_FRAC_BITS_DEF = 16;

	// Fixed field widths.
	localparam int CFRAC   = 16;
	localparam int DIR_W   = 18;
	localparam int T_W     = 32;
	localparam int BOX_W   = 11;
	localparam int STR_W   = 21;
	localparam int IDX_W   = 32;
	localparam int APB_AW  = 5;
	localparam int APB_DW  = 32;

	// Item operation codes.
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Register indexes.
	localparam logic [2:0] REG_BOX_X    = 3'd0;
	localparam logic [2:0] REG_BOX_Y    = 3'd1;
	localparam logic [2:0] REG_BOX_Z    = 3'd2;
	localparam logic [2:0] REG_STRIDE_X = 3'd3;
	localparam logic [2:0] REG_STRIDE_Y = 3'd4;
	localparam logic [2:0] REG_STRIDE_Z = 3'd5;

	// Register reset values.
	localparam logic [BOX_W-1:0] BOX_RST      = 11'd1024;
	localparam logic [STR_W-1:0] STRIDE_X_RST = 21'd1;
	localparam logic [STR_W-1:0] STRIDE_Y_RST = 21'd1024;
	localparam logic [STR_W-1:0] STRIDE_Z_RST = 21'd1048576;

endpackage

`default_nettype wire

@@ sv/ray_voxel_traversal_3d.sv @@
// ----------------------------------------------------------------------------
// ray_voxel_traversal_3d
// Amanatides-Woo voxel walk of a ray through a box with an APB register port.
// ----------------------------------------------------------------------------
// A step item (op = 1) is taken and its item appears on the output register
// in the next cycle; a start item without a hit finishes likewise. A start item
// with a hit runs a shared restoring divider, one quotient bit per cycle, twice
// for each axis with a nonzero direction (t per voxel and t to the first
// boundary), then the shared multiplier for the linear index, axis by axis.
// The input is stalled while it runs.
`default_nettype none

module ray_voxel_traversal_3d #(
	parameter int GRID_BITS   = rvt_pkg::GRID_BITS_DEF,
	parameter int T_FRAC_BITS = rvt_pkg::T_FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Input channel.
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic                                  op,
	input  wire logic                                  ray_hits,
	input  wire logic [GRID_BITS+rvt_pkg::CFRAC:0]     entry_x,
	input  wire logic [GRID_BITS+rvt_pkg::CFRAC:0]     entry_y,
	input  wire logic [GRID_BITS+rvt_pkg::CFRAC:0]     entry_z,
	input  wire logic signed [rvt_pkg::DIR_W-1:0]      dir_x,
	input  wire logic signed [rvt_pkg::DIR_W-1:0]      dir_y,
	input  wire logic signed [rvt_pkg::DIR_W-1:0]      dir_z,
	// Output channel.
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       in_box,
	output logic signed [GRID_BITS+1:0]                voxel_x,
	output logic signed [GRID_BITS+1:0]                voxel_y,
	output logic signed [GRID_BITS+1:0]                voxel_z,
	output logic signed [rvt_pkg::IDX_W-1:0]           voxel_index,
	output logic [rvt_pkg::T_W-1:0]                    segment_length,
	// Register port.
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [rvt_pkg::APB_AW-1:0]            paddr,
	input  wire logic [rvt_pkg::APB_DW-1:0]            pwdata,
	output logic [rvt_pkg::APB_DW-1:0]                 prdata,
	output logic                                       pready
);

	localparam int POSW = GRID_BITS + 2;
	localparam int EW   = GRID_BITS + rvt_pkg::CFRAC + 1;
	localparam int DW   = rvt_pkg::DIR_W;
	localparam int TW   = rvt_pkg::T_W;
	localparam int NW   = rvt_pkg::CFRAC + 1 + T_FRAC_BITS;
	localparam int QW   = (NW > TW) ? NW : TW;
	localparam int CW   = $clog2(NW + 1);
	localparam int DSTW = rvt_pkg::CFRAC + 1;

	typedef enum logic [2:0] {S_IDLE, S_LOAD, S_DIV, S_WB, S_MUL} state_t;

	state_t state_q;

	// Configuration registers.
	logic [rvt_pkg::BOX_W-1:0] box_q [3];
	logic [rvt_pkg::STR_W-1:0] stride_q [3];

	// Traversal state.
	logic signed [POSW-1:0] pos_q [3];
	logic                   neg_q [3];
	logic                   nz_q [3];
	logic [TW-1:0]          t_next_q [3];
	logic [TW-1:0]          t_delta_q [3];
	logic [TW-1:0]          t_exit_q;
	logic [TW-1:0]          lin_q;

	// Start bookkeeping and the shared divider.
	logic [DSTW-1:0]        dist_q [3];
	logic [DW-1:0]          ad_q [3];
	logic [1:0]             axis_q;
	logic                   kind_q;
	logic [NW-1:0]          div_n_q;
	logic [DW-1:0]          div_r_q;
	logic [CW-1:0]          div_cnt_q;

	// Output register.
	logic                   out_valid_q;
	logic                   in_box_q;
	logic signed [POSW-1:0] vox_q [3];
	logic [TW-1:0]          index_q;
	logic [TW-1:0]          seg_q;

	logic [EW-1:0]          entry [3];
	logic signed [DW-1:0]   dir [3];
	logic                   in_acc;
	logic                   out_set;
	logic                   cfg_wr;
	logic [2:0]             cfg_idx;

	assign entry[0] = entry_x;
	assign entry[1] = entry_y;
	assign entry[2] = entry_z;
	assign dir[0]   = dir_x;
	assign dir[1]   = dir_y;
	assign dir[2]   = dir_z;

	// Handshakes.
	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign cfg_idx  = paddr[4:2];

	// A result is ready after a step, a start without a hit, or the last index cycle.
	assign out_set = (state_q == S_IDLE && in_acc && (op == rvt_pkg::OP_STEP || !ray_hits))
		|| (state_q == S_MUL && axis_q == 2'd2);

	assign out_valid      = out_valid_q;
	assign in_box         = in_box_q;
	assign voxel_x        = vox_q[0];
	assign voxel_y        = vox_q[1];
	assign voxel_z        = vox_q[2];
	assign voxel_index    = index_q;
	assign segment_length = seg_q;

	// Box test of a position.
	function automatic logic inside_f(input logic signed [POSW-1:0] p,
		input logic [rvt_pkg::BOX_W-1:0] b);
		logic [TW-1:0] pu;
		pu = TW'($unsigned(p));
		return !p[POSW-1] && (pu < TW'(b));
	endfunction

	// Register read.
	always_comb begin
		unique case (cfg_idx)
			rvt_pkg::REG_BOX_X:    prdata = 32'(box_q[0]);
			rvt_pkg::REG_BOX_Y:    prdata = 32'(box_q[1]);
			rvt_pkg::REG_BOX_Z:    prdata = 32'(box_q[2]);
			rvt_pkg::REG_STRIDE_X: prdata = 32'(stride_q[0]);
			rvt_pkg::REG_STRIDE_Y: prdata = 32'(stride_q[1]);
			rvt_pkg::REG_STRIDE_Z: prdata = 32'(stride_q[2]);
			default:               prdata = '0;
		endcase
	end

	// Register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q[0]    <= rvt_pkg::BOX_RST;
			box_q[1]    <= rvt_pkg::BOX_RST;
			box_q[2]    <= rvt_pkg::BOX_RST;
			stride_q[0] <= rvt_pkg::STRIDE_X_RST;
			stride_q[1] <= rvt_pkg::STRIDE_Y_RST;
			stride_q[2] <= rvt_pkg::STRIDE_Z_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				rvt_pkg::REG_BOX_X:    box_q[0]    <= pwdata[rvt_pkg::BOX_W-1:0];
				rvt_pkg::REG_BOX_Y:    box_q[1]    <= pwdata[rvt_pkg::BOX_W-1:0];
				rvt_pkg::REG_BOX_Z:    box_q[2]    <= pwdata[rvt_pkg::BOX_W-1:0];
				rvt_pkg::REG_STRIDE_X: stride_q[0] <= pwdata[rvt_pkg::STR_W-1:0];
				rvt_pkg::REG_STRIDE_Y: stride_q[1] <= pwdata[rvt_pkg::STR_W-1:0];
				rvt_pkg::REG_STRIDE_Z: stride_q[2] <= pwdata[rvt_pkg::STR_W-1:0];
				default: ;
			endcase
		end
	end

	// Step item: smallest boundary t, the axes that hold it and their updates.
	logic [TW-1:0]          t_min;
	logic                   mask [3];
	logic signed [POSW-1:0] pos_nx [3];
	logic [TW-1:0]          tn_nx [3];
	logic [TW-1:0]          lin_nx;
	logic [TW:0]            tsum [3];

	always_comb begin
		t_min = t_next_q[0];
		if (t_next_q[1] < t_min) t_min = t_next_q[1];
		if (t_next_q[2] < t_min) t_min = t_next_q[2];
		lin_nx = lin_q;
		for (int k = 0; k < 3; k++) begin
			mask[k]   = (t_next_q[k] == t_min);
			tsum[k]   = {1'b0, t_next_q[k]} + {1'b0, t_delta_q[k]};
			pos_nx[k] = pos_q[k];
			tn_nx[k]  = t_next_q[k];
			if (mask[k]) begin
				tn_nx[k] = tsum[k][TW] ? '1 : tsum[k][TW-1:0];
				if (nz_q[k]) begin
					pos_nx[k] = neg_q[k] ? pos_q[k] - POSW'(1) : pos_q[k] + POSW'(1);
					lin_nx = neg_q[k] ? lin_nx - TW'(stride_q[k])
						: lin_nx + TW'(stride_q[k]);
				end
			end
		end
	end

	// Start item: first voxel, distance to the first boundary and |dir|.
	logic signed [POSW-1:0] pos_st [3];
	logic [DSTW-1:0]        dist_st [3];
	logic [DW-1:0]          ad_st [3];
	logic [rvt_pkg::CFRAC-1:0] frac [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			frac[k]   = entry[k][rvt_pkg::CFRAC-1:0];
			pos_st[k] = POSW'(entry[k][EW-1:rvt_pkg::CFRAC]);
			ad_st[k]  = dir[k][DW-1] ? DW'(-dir[k]) : DW'(dir[k]);
			if (!dir[k][DW-1]) begin
				dist_st[k] = DSTW'(1 << rvt_pkg::CFRAC) - DSTW'(frac[k]);
			end else if (frac[k] == '0) begin
				pos_st[k]  = pos_st[k] - POSW'(1);
				dist_st[k] = DSTW'(1 << rvt_pkg::CFRAC);
			end else begin
				dist_st[k] = DSTW'(frac[k]);
			end
		end
	end

	// Shared divider step and the shared index multiplier.
	logic [DW:0]                  div_trial;
	logic                         div_ge;
	logic [QW-1:0]                quo;
	logic [TW-1:0]                quo_sat;
	logic [rvt_pkg::STR_W+POSW:0] prod;

	always_comb begin
		div_trial = {div_r_q, div_n_q[NW-1]};
		div_ge    = div_trial >= {1'b0, ad_q[axis_q]};
		quo       = QW'(div_n_q);
		quo_sat   = (quo > QW'({TW{1'b1}})) ? '1 : quo[TW-1:0];
		prod      = $signed({1'b0, stride_q[axis_q]}) * pos_q[axis_q];
	end

	// Output valid: set by a finished item, cleared when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_set) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer, traversal state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			kind_q      <= 1'b0;
			div_cnt_q   <= '0;
			t_exit_q    <= '0;
			lin_q       <= '0;
			for (int k = 0; k < 3; k++) begin
				pos_q[k]     <= '0;
				neg_q[k]     <= 1'b0;
				nz_q[k]      <= 1'b0;
				t_next_q[k]  <= '1;
				t_delta_q[k] <= '1;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && op == rvt_pkg::OP_STEP) begin
						for (int k = 0; k < 3; k++) begin
							pos_q[k]    <= pos_nx[k];
							t_next_q[k] <= tn_nx[k];
							vox_q[k]    <= pos_nx[k];
						end
						lin_q       <= lin_nx;
						t_exit_q    <= t_min;
						in_box_q    <= inside_f(pos_nx[0], box_q[0])
							&& inside_f(pos_nx[1], box_q[1])
							&& inside_f(pos_nx[2], box_q[2]);
						index_q     <= lin_nx;
						seg_q       <= t_min - t_exit_q;
					end else if (in_acc) begin
						t_exit_q <= '0;
						lin_q    <= '0;
						for (int k = 0; k < 3; k++) begin
							t_next_q[k]  <= '1;
							t_delta_q[k] <= '1;
							pos_q[k]     <= ray_hits ? pos_st[k] : '0;
							neg_q[k]     <= ray_hits && dir[k][DW-1];
							nz_q[k]      <= ray_hits && (dir[k] != '0);
							dist_q[k]    <= dist_st[k];
							ad_q[k]      <= ad_st[k];
							vox_q[k]     <= '0;
						end
						if (ray_hits) begin
							state_q <= S_LOAD;
							axis_q  <= '0;
							kind_q  <= 1'b0;
						end else begin
							in_box_q    <= 1'b0;
							index_q     <= '0;
							seg_q       <= '0;
						end
					end
				end
				// Load the divider, or skip an axis with zero direction.
				S_LOAD: begin
					if (!nz_q[axis_q]) begin
						if (axis_q == 2'd2) begin
							state_q <= S_MUL;
							axis_q  <= '0;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						div_n_q   <= kind_q ? {dist_q[axis_q], T_FRAC_BITS'(0)}
							: {DSTW'(1 << rvt_pkg::CFRAC), T_FRAC_BITS'(0)};
						div_r_q   <= '0;
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end
				// One restoring quotient bit per cycle.
				S_DIV: begin
					div_r_q   <= div_ge ? DW'(div_trial - {1'b0, ad_q[axis_q]})
						: div_trial[DW-1:0];
					div_n_q   <= {div_n_q[NW-2:0], div_ge};
					div_cnt_q <= div_cnt_q + CW'(1);
					if (div_cnt_q == CW'(NW - 1)) state_q <= S_WB;
				end
				// Saturate and store the quotient, then pick the next division.
				S_WB: begin
					if (kind_q) begin
						t_next_q[axis_q] <= quo_sat;
						kind_q           <= 1'b0;
						if (axis_q == 2'd2) begin
							state_q <= S_MUL;
							axis_q  <= '0;
						end else begin
							axis_q  <= axis_q + 2'd1;
							state_q <= S_LOAD;
						end
					end else begin
						t_delta_q[axis_q] <= quo_sat;
						kind_q            <= 1'b1;
						state_q           <= S_LOAD;
					end
				end
				// Linear index, one axis per cycle, then the start item's result.
				S_MUL: begin
					lin_q <= lin_q + prod[TW-1:0];
					if (axis_q == 2'd2) begin
						state_q     <= S_IDLE;
						in_box_q    <= inside_f(pos_q[0], box_q[0])
							&& inside_f(pos_q[1], box_q[1])
							&& inside_f(pos_q[2], box_q[2]);
						index_q     <= lin_q + prod[TW-1:0];
						seg_q       <= '0;
						for (int k = 0; k < 3; k++) vox_q[k] <= pos_q[k];
					end else begin
						axis_q <= axis_q + 2'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/rvt_checker.sv @@
// ----------------------------------------------------------------------------
// rvt_checker
// Port-level checks of the voxel traversal block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ray_voxel_traversal_3d_defines.svh"

module rvt_checker #(
	parameter int GRID_BITS = rvt_pkg::GRID_BITS_DEF
) (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        op,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        in_box,
	input wire logic signed [GRID_BITS+1:0] voxel_x,
	input wire logic signed [GRID_BITS+1:0] voxel_y,
	input wire logic signed [GRID_BITS+1:0] voxel_z,
	input wire logic signed [31:0]          voxel_index
);

	// A waiting item stays.
	`RVT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	// A waiting item does not change its index.
	`RVT_ASSERT_NEXT(a_idx_hold, clk, arst_n, out_valid && out_stall, $stable(voxel_index))
	// A step item produces its result in the next cycle.
	`RVT_ASSERT_NEXT(a_step_lat, clk, arst_n,
		in_valid && !in_stall && op == rvt_pkg::OP_STEP, out_valid)
	// A voxel reported inside the box has no negative coordinate.
	`RVT_ASSERT_NOW(a_inside_pos, clk, arst_n, out_valid && in_box,
		!voxel_x[GRID_BITS+1] && !voxel_y[GRID_BITS+1] && !voxel_z[GRID_BITS+1])

endmodule

bind ray_voxel_traversal_3d rvt_checker #(.GRID_BITS(GRID_BITS)) u_rvt_checker (.*);

`default_nettype wire
